/* rtl/core/otp_pkg.sv */
`default_nettype none

package otp_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAVITY   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_STEP = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_STEPS = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam int COORD_BITS   = 32;
    localparam int DIFF_BITS    = 33;
    localparam int MAX_STEP_BITS = 14;
    localparam int DOT_FROM     = 11;

    typedef struct packed {
        logic start;
    } norm_req_t;

    typedef struct packed {
        logic done;
    } norm_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/orbit_trajectory_predictor.sv */
// Channel   Dir  Payload
// s_*       in   tuser: command; tdata: start_x, y, z, vx, vy, vz
// m_*       out  tdata: point_x, y, z, step_index; tlast: last
// cfg_*     in   write enable, register index, data
//
// A load item holds s_tready low while the direction unit runs: shift search,
// squares of the three axes, 32 square-root iterations, 3 x (FRAC_BITS+1) divide
// iterations and a done state (a zero offset goes from shift search to done).
// A step item then adds 12 products on the shared multiplier, a decision
// state and an output state; one that ends the run skips the Euler products.
// One item at a time; s_tready is high only while idle.
// A finished item waits in the output register; a further item is taken
// meanwhile and stalls only at its own result. Reset clears top-level control state.
`default_nettype none

module orbit_trajectory_predictor
    import otp_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int STEP_COUNT_BITS = 14
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [191:0]               s_tdata,  // start_x, start_y, start_z, start_vx, start_vy, start_vz
    input  wire logic [0:0]                 s_tuser,  // command
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [((96+STEP_COUNT_BITS+7)/8)*8-1:0] m_tdata, // point_x, point_y, point_z, step_index
    output logic                            m_tlast,  // last
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int UW = FRAC_BITS + 2;
    localparam int DW = 2 * FRAC_BITS + 4;
    localparam int SCB = STEP_COUNT_BITS;
    localparam int OUT_W = ((96 + STEP_COUNT_BITS + 7) / 8) * 8;
    localparam int CW = ((SCB > MAX_STEP_BITS) ? SCB : MAX_STEP_BITS) + 1;
    localparam logic signed [DW-1:0] DOT_LO = -(DW'(1) << (2 * FRAC_BITS - 1));
    localparam logic signed [DW-1:0] DOT_HI = DW'((64'd95 << (2 * FRAC_BITS)) / 64'd100);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_KICK = 7'b0000010,
        S_NORM = 7'b0000100,
        S_DOT  = 7'b0001000,
        S_DEC  = 7'b0010000,
        S_EUL  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] grav_reg;
    logic [15:0] ts_reg;
    logic [MAX_STEP_BITS-1:0] maxs_reg;

    logic [2:0][31:0]     pos_reg, pos_next;
    logic [2:0][31:0]     vel_reg, vel_next;
    logic [2:0][UW-1:0]   sdir_reg, sdir_next;
    logic                 passed_reg, passed_next;
    logic [SCB-1:0]       count_reg, count_next;
    logic                 active_reg, active_next;
    logic                 load_reg, load_next;
    logic                 last_reg, last_next;
    logic [95:0]          pt_reg, pt_next;
    logic [SCB-1:0]       idx_reg, idx_next;
    logic signed [DW-1:0] dot_reg, dot_next;
    logic [1:0]           axis_reg, axis_next;
    logic [1:0]           sub_reg, sub_next;
    logic                 ph_reg, ph_next;
    logic [31:0]          acc_reg, acc_next;
    logic                 accn_reg, accn_next;
    logic [63:0]          prod_reg, prod_next;
    logic                 pneg_reg, pneg_next;
    logic                 mv_reg, mv_next;
    logic [OUT_W-1:0]     md_reg, md_next;
    logic                 ml_reg, ml_next;

    norm_req_t nreq;
    norm_rsp_t nrsp;
    logic [2:0][DIFF_BITS-1:0] diff;
    logic [2:0][UW-1:0] unit;

    logic [UW-1:0] u_sel, u_mag, s_sel, s_mag;
    logic [31:0] v_sel, v_mag;
    logic [31:0] mul_a, mul_b;
    logic mul_neg;
    logic [63:0] shq;
    logic signed [64:0] sval;
    logic accept;
    logic ge_from, end_cnt, dot_lt, dot_gt;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [64:0] v);
        logic signed [65:0] s;
        s = $signed({{34{a[31]}}, a}) + $signed({v[64], v});
        if (s > 66'sh0_7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (s < -66'sh0_8000_0000)
        begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            grav_reg <= 31'd106168;
            ts_reg   <= 16'd1311;
            maxs_reg <= 14'd10000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:  cx_reg   <= cfg_data;
                CFG_CENTER_Y:  cy_reg   <= cfg_data;
                CFG_CENTER_Z:  cz_reg   <= cfg_data;
                CFG_GRAVITY:   grav_reg <= cfg_data[30:0];
                CFG_TIME_STEP: ts_reg   <= cfg_data[15:0];
                CFG_MAX_STEPS: maxs_reg <= cfg_data[MAX_STEP_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign diff[0] = DIFF_BITS'($signed(pos_reg[0])) - DIFF_BITS'(cx_reg);
    assign diff[1] = DIFF_BITS'($signed(pos_reg[1])) - DIFF_BITS'(cy_reg);
    assign diff[2] = DIFF_BITS'($signed(pos_reg[2])) - DIFF_BITS'(cz_reg);
    assign nreq.start = (state_reg == S_KICK);

    otp_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .diff  (diff),
        .rsp   (nrsp),
        .unit  (unit)
    );

    assign u_sel = unit[axis_reg];
    assign u_mag = u_sel[UW-1] ? UW'(-u_sel) : u_sel;
    assign s_sel = sdir_reg[axis_reg];
    assign s_mag = s_sel[UW-1] ? UW'(-s_sel) : s_sel;
    assign v_sel = vel_reg[axis_reg];
    assign v_mag = v_sel[31] ? 32'(-v_sel) : v_sel;

    always_comb
    begin
        mul_a   = 32'(u_mag);
        mul_b   = 32'(s_mag);
        mul_neg = u_sel[UW-1] ^ s_sel[UW-1];
        if (state_reg == S_EUL)
        begin
            case (sub_reg)
                2'd0:
                begin
                    mul_b   = {1'b0, grav_reg};
                    mul_neg = !u_sel[UW-1] && (u_sel != '0);
                end
                2'd1:
                begin
                    mul_a   = acc_reg;
                    mul_b   = 32'(ts_reg);
                    mul_neg = accn_reg;
                end
                default:
                begin
                    mul_a   = v_mag;
                    mul_b   = 32'(ts_reg);
                    mul_neg = v_sel[31];
                end
            endcase
        end
    end

    assign shq  = (state_reg == S_DOT) ? prod_reg : (prod_reg >> FRAC_BITS);
    assign sval = pneg_reg ? -$signed({1'b0, shq}) : $signed({1'b0, shq});

    assign accept  = s_tvalid && s_tready;
    assign ge_from = (count_reg >= SCB'(DOT_FROM));
    assign end_cnt = ((CW'(count_reg) + CW'(1)) >= CW'(maxs_reg)) || (&count_reg);
    assign dot_lt  = (dot_reg < DOT_LO);
    assign dot_gt  = (dot_reg > DOT_HI);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        sdir_next   = sdir_reg;
        passed_next = passed_reg;
        count_next  = count_reg;
        active_next = active_reg;
        load_next   = load_reg;
        last_next   = last_reg;
        pt_next     = pt_reg;
        idx_next    = idx_reg;
        dot_next    = dot_reg;
        axis_next   = axis_reg;
        sub_next    = sub_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        accn_next   = accn_reg;
        prod_next   = prod_reg;
        pneg_next   = pneg_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        ml_next     = ml_reg;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == CMD_LOAD)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_next[i] = s_tdata[32*i +: 32];
                            vel_next[i] = s_tdata[96 + 32*i +: 32];
                        end
                        load_next  = 1'b1;
                        state_next = S_KICK;
                    end
                    else if (active_reg)
                    begin
                        pt_next    = {pos_reg[2], pos_reg[1], pos_reg[0]};
                        idx_next   = count_reg;
                        load_next  = 1'b0;
                        state_next = S_KICK;
                    end
                end
            end
            S_KICK:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (nrsp.done)
                begin
                    if (load_reg)
                    begin
                        sdir_next   = unit;
                        passed_next = 1'b0;
                        count_next  = '0;
                        active_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        dot_next   = '0;
                        axis_next  = '0;
                        ph_next    = 1'b0;
                        state_next = S_DOT;
                    end
                end
            end
            S_DOT:
            begin
                if (!ph_reg)
                begin
                    prod_next = mul_a * mul_b;
                    pneg_next = mul_neg;
                    ph_next   = 1'b1;
                end
                else
                begin
                    dot_next = dot_reg + sval[DW-1:0];
                    ph_next  = 1'b0;
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_DEC;
                    end
                end
            end
            S_DEC:
            begin
                last_next = end_cnt;
                if (ge_from)
                begin
                    passed_next = passed_reg || dot_lt;
                    if ((passed_reg || dot_lt) && dot_gt)
                    begin
                        last_next = 1'b1;
                    end
                end
                axis_next = '0;
                sub_next  = '0;
                ph_next   = 1'b0;
                if (last_next)
                begin
                    active_next = 1'b0;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_EUL;
                end
            end
            S_EUL:
            begin
                if (!ph_reg)
                begin
                    prod_next = mul_a * mul_b;
                    pneg_next = mul_neg;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    case (sub_reg)
                        2'd0:
                        begin
                            acc_next  = shq[31:0];
                            accn_next = pneg_reg;
                            sub_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            vel_next[axis_reg] = sat_add(vel_reg[axis_reg], sval);
                            sub_next = 2'd2;
                        end
                        default:
                        begin
                            pos_next[axis_reg] = sat_add(pos_reg[axis_reg], sval);
                            sub_next  = 2'd0;
                            axis_next = axis_reg + 2'd1;
                            if (axis_reg == 2'd2)
                            begin
                                count_next = count_reg + SCB'(1);
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = OUT_W'({idx_reg, pt_reg});
                    ml_next    = last_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            vel_reg    <= '0;
            sdir_reg   <= '0;
            passed_reg <= 1'b0;
            count_reg  <= '0;
            active_reg <= 1'b0;
            load_reg   <= 1'b0;
            last_reg   <= 1'b0;
            axis_reg   <= '0;
            sub_reg    <= '0;
            ph_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            sdir_reg   <= sdir_next;
            passed_reg <= passed_next;
            count_reg  <= count_next;
            active_reg <= active_next;
            load_reg   <= load_next;
            last_reg   <= last_next;
            axis_reg   <= axis_next;
            sub_reg    <= sub_next;
            ph_reg     <= ph_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg   <= pt_next;
        idx_reg  <= idx_next;
        dot_reg  <= dot_next;
        acc_reg  <= acc_next;
        accn_reg <= accn_next;
        prod_reg <= prod_next;
        pneg_reg <= pneg_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

`default_nettype wire

/* rtl/core/otp_norm.sv */
`default_nettype none

module otp_norm
    import otp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire norm_req_t                            req,
    input  wire logic [2:0][DIFF_BITS-1:0]            diff,
    output norm_rsp_t                                 rsp,
    output logic      [2:0][FRAC_BITS+1:0]            unit
);

    localparam int QW = FRAC_BITS + 1;
    localparam int UW = FRAC_BITS + 2;
    localparam int DCW = $clog2(QW);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } nstate_t;

    nstate_t state_reg, state_next;
    logic [2:0][DIFF_BITS-1:0] b_reg, b_next;
    logic [2:0]       neg_reg, neg_next;
    logic [63:0]      sum_reg, sum_next;
    logic [61:0]      prod_reg, prod_next;
    logic [1:0]       k_reg, k_next;
    logic             ph_reg, ph_next;
    logic [63:0]      n_reg, n_next;
    logic [63:0]      r_reg, r_next;
    logic [4:0]       it_reg, it_next;
    logic [32:0]      rem_reg, rem_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;
    logic [2:0][UW-1:0] unit_reg, unit_next;

    logic [DIFF_BITS-1:0] m;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [32:0] shifted;
    logic [QW-1:0] qn;
    logic [30:0] bk;

    always_comb
    begin
        m = b_reg[0];
        if (b_reg[1] > m)
        begin
            m = b_reg[1];
        end
        if (b_reg[2] > m)
        begin
            m = b_reg[2];
        end
    end

    assign bk    = b_reg[k_reg][30:0];
    assign bitv  = 64'd1 << (6'd62 - {it_reg, 1'b0});
    assign trial = r_reg + bitv;
    assign shifted = {rem_reg[31:0], (dcnt_reg == '0) ? bk[0] : 1'b0};

    always_comb
    begin
        state_next = state_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        prod_next  = prod_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        it_next    = it_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        dcnt_next  = dcnt_reg;
        unit_next  = unit_reg;
        qn         = '0;
        case (state_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = diff[i][DIFF_BITS-1];
                        b_next[i]   = diff[i][DIFF_BITS-1] ? DIFF_BITS'(-diff[i]) : diff[i];
                    end
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (m == '0)
                begin
                    unit_next  = '0;
                    state_next = N_DONE;
                end
                else if (m[32:31] != 2'b00)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        b_next[i] = b_reg[i] >> 1;
                    end
                end
                else if (m[32:30] == 3'b000)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        b_next[i] = b_reg[i] << 1;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    k_next     = '0;
                    ph_next    = 1'b0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (!ph_reg)
                begin
                    prod_next = bk * bk;
                    ph_next   = 1'b1;
                end
                else
                begin
                    sum_next = sum_reg + 64'(prod_reg);
                    ph_next  = 1'b0;
                    if (k_reg == 2'd2)
                    begin
                        n_next     = sum_reg + 64'(prod_reg);
                        r_next     = '0;
                        it_next    = '0;
                        state_next = N_SQRT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            N_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    r_next = (r_reg >> 1) + bitv;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd31)
                begin
                    k_next     = '0;
                    rem_next   = {3'b000, b_reg[0][30:1]};
                    q_next     = '0;
                    dcnt_next  = '0;
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                if (shifted >= {1'b0, r_reg[31:0]})
                begin
                    rem_next = shifted - {1'b0, r_reg[31:0]};
                    qn = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    qn = {q_reg[QW-2:0], 1'b0};
                end
                q_next    = qn;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(QW - 1))
                begin
                    unit_next[k_reg] = neg_reg[k_reg] ? UW'(-{1'b0, qn}) : UW'({1'b0, qn});
                    if (k_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        k_next    = k_reg + 2'd1;
                        rem_next  = {3'b000, b_reg[k_reg + 2'd1][30:1]};
                        q_next    = '0;
                        dcnt_next = '0;
                    end
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        neg_reg  <= neg_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        ph_reg   <= ph_next;
        n_reg    <= n_next;
        r_reg    <= r_next;
        it_reg   <= it_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dcnt_reg <= dcnt_next;
        unit_reg <= unit_next;
    end

    assign rsp.done = (state_reg == N_DONE);
    assign unit     = unit_reg;

endmodule

`default_nettype wire

/* rtl/core/otp_checker.sv */
`default_nettype none

module otp_checker
    import otp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [0:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic       m_tlast
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
        else $error("output item dropped or changed while stalled");

    // a load always keeps the block busy
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD) |=> !s_tready)
        else $error("block ready straight after a load");

    // a new result only appears after work while not ready
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    // a load emits no result: nothing emitted the cycle after a load
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD) |=> !$rose(m_tvalid))
        else $error("load produced a result");

endmodule

bind orbit_trajectory_predictor otp_checker u_otp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

`default_nettype wire
